// ----- sv/view_transform_and_project_macros.svh -----
// ----------------------------------------------------------------------------
// View transform and projection assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef VIEW_TRANSFORM_AND_PROJECT_MACROS_SVH
`define VIEW_TRANSFORM_AND_PROJECT_MACROS_SVH

// same-cycle implication
`define VTP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("view transform check failed");

// next-cycle implication
`define VTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("view transform check failed");

`endif

// ----- sv/vtp_pkg.sv -----
// ----------------------------------------------------------------------------
// View transform and projection package
// Shared constants and types of the view transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

  localparam int COEF_COUNT = 12;
  localparam int VIEW_BASE  = 9;
  localparam int COEF_IDX_W = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int DIV_BITS   = 33;
  localparam int MAG_W      = 63;
  localparam int DEN_W      = 31;

  localparam logic REQ_LOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEIGHT_SCALE = 4'd0,
    CFG_WIDTH_SCALE  = 4'd1,
    CFG_BIAS_X       = 4'd2,
    CFG_BIAS_Y       = 4'd3
  } cfg_e;

  typedef logic [COEF_COUNT-1:0][31:0] coef_arr_t;

  typedef struct packed {
    logic [2:0][31:0]          rot;
    logic                      front;
    logic [DEN_W-1:0]          den;
    logic [1:0]                neg;
    logic [1:0]                big;
    logic [1:0][MAG_W-1:0]     rem;
    logic [1:0][DIV_BITS-1:0]  quo;
  } div_t;

endpackage

`default_nettype wire

// ----- sv/view_transform_and_project.sv -----
// ----------------------------------------------------------------------------
// View transform and perspective projection
// Translate and rotate world points, then project in front of the eye.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  in       | input     | in_valid/in_ready     | req_type coef_index coef_value pos_*
//  cfg      | input     | cfg_valid/cfg_ready   | cfg_index cfg_data
//  out      | output    | out_valid/out_ready   | rot_* screen_* in_front projected overflow
//
// One point per cycle while the output is not stalled; the 33 one-bit restoring
// divide stages follow the multiply and sum stages.
// Loads write the coefficient store on acceptance and make no result.
// Reset clears the store, the config registers and all stage valid bits.
// Each stage holds under stall and fills when its successor moves or is empty.
`default_nettype none

module view_transform_and_project #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          req_type_i,
  input  wire logic [vtp_pkg::COEF_IDX_W-1:0] coef_index_i,
  input  wire logic signed [31:0]            coef_value_i,
  input  wire logic signed [31:0]            pos_x_i,
  input  wire logic signed [31:0]            pos_y_i,
  input  wire logic signed [31:0]            pos_z_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [31:0]                 rot_x_o,
  output logic signed [31:0]                 rot_y_o,
  output logic signed [31:0]                 rot_z_o,
  output logic signed [31:0]                 screen_x_o,
  output logic signed [31:0]                 screen_y_o,
  output logic                               in_front_o,
  output logic                               projected_o,
  output logic                               overflow_o
);
  import vtp_pkg::*;

  localparam int DIV_BASE = 5;
  localparam int NS       = DIV_BASE + DIV_BITS + 2;

  logic [NS-1:0] vld_q;
  logic [NS:0]   ld;
  logic          acc_in, acc_pt, acc_ld;

  logic [30:0] hscale_q, wscale_q;
  logic [31:0] bias_x_q, bias_y_q;
  coef_arr_t   coef;

  always_comb begin
    ld[NS] = out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  assign in_ready_o  = ld[0];
  assign cfg_ready_o = 1'b1;
  assign acc_in      = in_valid_i && in_ready_o;
  assign acc_pt      = acc_in && (req_type_i != REQ_LOAD);
  assign acc_ld      = acc_in && (req_type_i == REQ_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= acc_pt;
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hscale_q <= '0;
      wscale_q <= '0;
      bias_x_q <= '0;
      bias_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEIGHT_SCALE: hscale_q <= cfg_data_i[30:0];
        CFG_WIDTH_SCALE:  wscale_q <= cfg_data_i[30:0];
        CFG_BIAS_X:       bias_x_q <= cfg_data_i;
        CFG_BIAS_Y:       bias_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  vtp_coef_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (acc_ld),
    .wr_idx_i  (coef_index_i),
    .wr_data_i (coef_value_i),
    .coef_o    (coef)
  );

  // translate, capture matrix
  logic [2:0][31:0] d_q;
  logic [8:0][31:0] m_q;

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      d_q[0] <= pos_x_i - coef[VIEW_BASE];
      d_q[1] <= pos_y_i - coef[VIEW_BASE+1];
      d_q[2] <= pos_z_i - coef[VIEW_BASE+2];
      for (int i = 0; i < 9; i++) begin
        m_q[i] <= coef[i];
      end
    end
  end

  // products: prod_q[c][a] = d[a] * m[3a+c]
  logic [2:0][2:0][63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      for (int c = 0; c < 3; c++) begin
        for (int a = 0; a < 3; a++) begin
          prod_q[c][a] <= $signed(d_q[a]) * $signed(m_q[3*a+c]);
        end
      end
    end
  end

  // sums and scaling
  logic [2:0][31:0] rot2_q;

  always_ff @(posedge clk_i) begin
    if (ld[2]) begin
      for (int c = 0; c < 3; c++) begin
        rot2_q[c] <= 32'((prod_q[c][0] + prod_q[c][1] + prod_q[c][2]) >> FRACTION_BITS);
      end
    end
  end

  // scale products
  logic [2:0][31:0] rot3_q;
  logic [1:0][63:0] sp3_q;
  logic             front3_q;

  always_ff @(posedge clk_i) begin
    if (ld[3]) begin
      rot3_q   <= rot2_q;
      sp3_q[0] <= $signed(rot2_q[1]) * $signed({1'b0, hscale_q});
      sp3_q[1] <= $signed(rot2_q[0]) * $signed({1'b0, wscale_q});
      front3_q <= $signed(rot2_q[2]) > 0;
    end
  end

  // magnitudes
  logic [2:0][31:0]      rot4_q;
  logic [1:0][MAG_W-1:0] mag4_q;
  logic [1:0]            neg4_q;
  logic                  front4_q;

  always_ff @(posedge clk_i) begin
    if (ld[4]) begin
      rot4_q   <= rot3_q;
      front4_q <= front3_q;
      for (int l = 0; l < 2; l++) begin
        neg4_q[l] <= sp3_q[l][63];
        mag4_q[l] <= sp3_q[l][63] ? MAG_W'(-sp3_q[l]) : MAG_W'(sp3_q[l]);
      end
    end
  end

  // range check and divide
  div_t dv_q [DIV_BITS+1];

  always_ff @(posedge clk_i) begin
    div_t        nxt;
    logic [63:0] sh;
    logic [63:0] rx;
    if (ld[DIV_BASE]) begin
      nxt.rot   = rot4_q;
      nxt.front = front4_q;
      nxt.den   = rot4_q[2][DEN_W-1:0];
      nxt.neg   = neg4_q;
      nxt.quo   = '0;
      for (int l = 0; l < 2; l++) begin
        nxt.rem[l] = mag4_q[l];
        nxt.big[l] = {1'b0, mag4_q[l]} >= {rot4_q[2][DEN_W-1:0], {DIV_BITS{1'b0}}};
      end
      dv_q[0] <= nxt;
    end
    for (int j = 0; j < DIV_BITS; j++) begin
      if (ld[DIV_BASE+1+j]) begin
        nxt = dv_q[j];
        sh  = 64'(dv_q[j].den) << (DIV_BITS - 1 - j);
        for (int l = 0; l < 2; l++) begin
          rx = {1'b0, dv_q[j].rem[l]};
          if (rx >= sh) begin
            nxt.rem[l]                  = MAG_W'(rx - sh);
            nxt.quo[l][DIV_BITS - 1 - j] = 1'b1;
          end
        end
        dv_q[j+1] <= nxt;
      end
    end
  end

  // sign, bias, flags
  div_t        fin;
  logic [31:0] q32_y, q32_x, ny;
  logic [32:0] sum_y, sum_x;
  logic        ovf_all;
  logic [1:0]  qovf;

  always_comb begin
    fin = dv_q[DIV_BITS];
    for (int l = 0; l < 2; l++) begin
      qovf[l] = fin.big[l] ||
                (fin.neg[l] ? (fin.quo[l] > {2'b01, 31'b0}) : (fin.quo[l][32:31] != 2'b00));
    end
    q32_y = fin.neg[0] ? 32'(-fin.quo[0]) : fin.quo[0][31:0];
    q32_x = fin.neg[1] ? 32'(-fin.quo[1]) : fin.quo[1][31:0];
    ny    = -q32_y;
    sum_y = {ny[31], ny} + {bias_y_q[31], bias_y_q};
    sum_x = {q32_x[31], q32_x} + {bias_x_q[31], bias_x_q};
    ovf_all = fin.front && (qovf[0] || qovf[1] || (sum_y[32] != sum_y[31]) ||
                            (sum_x[32] != sum_x[31]));
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      rot_x_o     <= fin.rot[0];
      rot_y_o     <= fin.rot[1];
      rot_z_o     <= fin.rot[2];
      in_front_o  <= fin.front;
      overflow_o  <= ovf_all;
      projected_o <= fin.front && !ovf_all;
      screen_x_o  <= (fin.front && !ovf_all) ? sum_x[31:0] : '0;
      screen_y_o  <= (fin.front && !ovf_all) ? sum_y[31:0] : '0;
    end
  end

  assign out_valid_o = vld_q[NS-1];

endmodule

`default_nettype wire

// ----- sv/vtp_coef_store.sv -----
// ----------------------------------------------------------------------------
// Coefficient store
// Twelve words: view matrix row major, then view position x, y, z.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_coef_store (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [vtp_pkg::COEF_IDX_W-1:0] wr_idx_i,
  input  wire logic [31:0]                    wr_data_i,
  output vtp_pkg::coef_arr_t                  coef_o
);
  import vtp_pkg::*;

  coef_arr_t coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (wr_en_i && (int'(wr_idx_i) < COEF_COUNT)) begin
      coef_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ----- sv/vtp_checker.sv -----
// ----------------------------------------------------------------------------
// View transform and projection checker
// Port-level checks on result flags and output hold, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "view_transform_and_project_macros.svh"

module vtp_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [31:0] screen_x_o,
  input wire logic signed [31:0] screen_y_o,
  input wire logic               in_front_o,
  input wire logic               projected_o,
  input wire logic               overflow_o
);

  `VTP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(screen_x_o) && $stable(screen_y_o))
  `VTP_ASSERT_NOW(a_proj_front, out_valid_o && projected_o, in_front_o)
  `VTP_ASSERT_NOW(a_behind_clean, out_valid_o && !in_front_o, !overflow_o && screen_x_o == 0 && screen_y_o == 0)
  `VTP_ASSERT_NOW(a_proj_xor_ovf, out_valid_o && in_front_o, projected_o != overflow_o)

endmodule

bind view_transform_and_project vtp_checker u_vtp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .screen_x_o  (screen_x_o),
  .screen_y_o  (screen_y_o),
  .in_front_o  (in_front_o),
  .projected_o (projected_o),
  .overflow_o  (overflow_o)
);

`default_nettype wire
